@@ design/tkps_pkg.sv @@
// shared types and constants for the top-k height point selector
package tkps_pkg;

    localparam int DEF_NUM_CELLS = 5;
    localparam int COORD_W       = 16;
    localparam int COUNT_W       = 3;
    localparam int RANK_W        = 3;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 88;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [COUNT_W-1:0] SELECT_COUNT_RESET = 3'd5;

    // one radar point as stored in a cell
    typedef struct packed {
        logic [COORD_W-1:0] snr;
        logic [COORD_W-1:0] velocity;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] height;
    } point_t;

    // one decoded input beat
    typedef struct packed {
        logic   set_end;
        point_t pt;
    } item_t;

endpackage

@@ design/top_k_height_point_select_top.sv @@
// top level of the streaming top-k height point selector
//
// Keeps the select_count highest radar points of each set in a sorted cell
// array and reports them, highest first, after the beat marked tlast. One
// point is taken per clock cycle while no set end waits: a four-entry queue
// feeds the cell array, which compares the new height against every cell at
// once and inserts it. The report of a set leaves at up to one beat a cycle
// from an output register, k beats for k kept points. A set end waits in the
// queue while the previous report still has beats to move into the output
// register and is taken in the same cycle as the last of them moves, so with
// the output ready a set end only stalls when its set has fewer points than
// the report ahead of it has beats. On its way to the first report beat a set
// end passes through the queue, the captured list and the output register.
module top_k_height_point_select_top
#(
    parameter int NUM_CELLS = tkps_pkg::DEF_NUM_CELLS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // select_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkps_pkg::COUNT_W-1:0]        cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_height, point_x, point_y, point_velocity, point_snr
    input  logic [tkps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // set_end
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rank, sel_height, sel_x, sel_y, sel_velocity, sel_snr, zero padding
    output logic [tkps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // run_last
    output logic                                m_axis_tlast
);

    localparam int KW = $clog2(NUM_CELLS + 1);

    logic [tkps_pkg::COUNT_W-1:0]   select_count_reg;
    logic [KW-1:0]                  keep_count;
    tkps_pkg::item_t                item;
    logic                           item_valid;
    logic                           item_ready;
    logic                           drain_busy;
    logic                           snap_load;
    logic [NUM_CELLS-1:0]           snap_valid;
    tkps_pkg::point_t               snap_pt [NUM_CELLS];

    // select_count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            select_count_reg <= tkps_pkg::SELECT_COUNT_RESET;
        else if (cfg_valid && cfg_ready)
            select_count_reg <= cfg_data;
    end

    // clamp the count to one through the cell count
    always_comb
    begin
        if (select_count_reg == '0)
            keep_count = KW'(1);
        else if (int'(select_count_reg) > NUM_CELLS)
            keep_count = KW'(NUM_CELLS);
        else
            keep_count = KW'(select_count_reg);
    end

    tkps_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item          (item),
        .item_valid    (item_valid),
        .item_ready    (item_ready)
    );

    tkps_cells #(.NUM_CELLS(NUM_CELLS), .KW(KW)) u_cells
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .keep_count (keep_count),
        .drain_busy (drain_busy),
        .snap_load  (snap_load),
        .snap_valid (snap_valid),
        .snap_pt    (snap_pt)
    );

    tkps_drain #(.NUM_CELLS(NUM_CELLS)) u_drain
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_load     (snap_load),
        .snap_valid    (snap_valid),
        .snap_pt       (snap_pt),
        .drain_busy    (drain_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ design/tkps_front.sv @@
// front end: input beat decode and a short queue towards the cell array
module tkps_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tkps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               s_axis_tlast,
    output tkps_pkg::item_t                    item,
    output logic                               item_valid,
    input  logic                               item_ready
);

    localparam int PTR_W = $clog2(tkps_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(tkps_pkg::FIFO_DEPTH + 1);

    tkps_pkg::item_t    fifo_mem [tkps_pkg::FIFO_DEPTH];
    tkps_pkg::item_t    push_item;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    // unpack the beat: height, x, y, velocity, snr from the lowest bit up
    always_comb
    begin
        push_item.pt      = tkps_pkg::point_t'(s_axis_tdata);
        push_item.set_end = s_axis_tlast;
    end

    assign s_axis_tready = (count_reg != CNT_W'(tkps_pkg::FIFO_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (count_reg != '0);
    assign pop           = item_valid && item_ready;
    assign item          = fifo_mem[rd_ptr_reg];

    // queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_item;
    end

endmodule

@@ design/tkps_cells.sv @@
// back end: sorted cell array with parallel compare and shift insertion
module tkps_cells
#(
    parameter int NUM_CELLS = tkps_pkg::DEF_NUM_CELLS,
    parameter int KW        = $clog2(NUM_CELLS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tkps_pkg::item_t         item,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [KW-1:0]           keep_count,
    input  logic                    drain_busy,
    output logic                    snap_load,
    output logic [NUM_CELLS-1:0]    snap_valid,
    output tkps_pkg::point_t        snap_pt [NUM_CELLS]
);

    logic [NUM_CELLS-1:0]   valid_reg;
    logic [NUM_CELLS-1:0]   valid_next;
    tkps_pkg::point_t       cell_pt_reg [NUM_CELLS];
    tkps_pkg::point_t       cell_pt_next [NUM_CELLS];
    logic [NUM_CELLS-1:0]   in_k;
    logic [NUM_CELLS-1:0]   higher;
    logic [NUM_CELLS-1:0]   take;
    logic [NUM_CELLS-1:0]   shift;
    logic                   fire;

    // a set end waits while the previous set is still being reported
    assign item_ready = !(item.set_end && drain_busy);
    assign fire       = item_valid && item_ready;

    // per-cell compare against the incoming height
    always_comb
    begin
        for (int j = 0; j < NUM_CELLS; j++)
        begin
            in_k[j]   = (int'(keep_count) > j);
            higher[j] = in_k[j] && (!valid_reg[j] ||
                        ($signed(item.pt.height) > $signed(cell_pt_reg[j].height)));
        end
    end

    // first hit takes the point, cells below it inside the window move down
    always_comb
    begin
        logic seen;
        int   pj;
        seen = 1'b0;
        pj   = 0;
        for (int j = 0; j < NUM_CELLS; j++)
        begin
            take[j]  = higher[j] && !seen;
            shift[j] = seen && in_k[j];
            seen     = seen | higher[j];
        end
        for (int j = 0; j < NUM_CELLS; j++)
        begin
            pj = (j > 0) ? j - 1 : 0;
            if (take[j])
            begin
                valid_next[j]   = 1'b1;
                cell_pt_next[j] = item.pt;
            end
            else if (shift[j])
            begin
                valid_next[j]   = valid_reg[pj];
                cell_pt_next[j] = cell_pt_reg[pj];
            end
            else
            begin
                valid_next[j]   = valid_reg[j];
                cell_pt_next[j] = cell_pt_reg[j];
            end
        end
    end

    // hand the updated list to the report sequencer on a set end
    assign snap_load  = fire && item.set_end;
    assign snap_valid = valid_next & in_k;
    assign snap_pt    = cell_pt_next;

    // valid bits, cleared at the end of every set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (fire)
            valid_reg <= item.set_end ? '0 : valid_next;
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (fire && !item.set_end)
            cell_pt_reg <= cell_pt_next;
    end

endmodule

@@ design/tkps_drain.sv @@
// report sequencer: walks a captured list in rank order into the output register
module tkps_drain
#(
    parameter int NUM_CELLS = tkps_pkg::DEF_NUM_CELLS,
    parameter int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                snap_load,
    input  logic [NUM_CELLS-1:0]                snap_valid,
    input  tkps_pkg::point_t                    snap_pt [NUM_CELLS],
    output logic                                drain_busy,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tkps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int PAD_W = tkps_pkg::OUT_TDATA_W - tkps_pkg::RANK_W
                           - $bits(tkps_pkg::point_t);

    logic [NUM_CELLS-1:0]           mask_reg;
    tkps_pkg::point_t               list_reg [NUM_CELLS];
    logic [IDX_W-1:0]               pick_idx;
    logic [NUM_CELLS-1:0]           pick_oh;
    logic [NUM_CELLS-1:0]           rest;
    logic                           pending;
    logic                           emit;
    logic                           out_valid_reg;
    logic                           out_last_reg;
    logic [tkps_pkg::RANK_W-1:0]    out_rank_reg;
    tkps_pkg::point_t               out_pt_reg;

    // lowest remaining rank
    always_comb
    begin
        logic found;
        found    = 1'b0;
        pick_idx = '0;
        pick_oh  = '0;
        for (int j = 0; j < NUM_CELLS; j++)
        begin
            if (mask_reg[j] && !found)
            begin
                found      = 1'b1;
                pick_idx   = IDX_W'(j);
                pick_oh[j] = 1'b1;
            end
        end
    end

    assign rest    = mask_reg & ~pick_oh;
    assign pending = |mask_reg;
    assign emit    = pending && (!out_valid_reg || m_axis_tready);

    // the captured list frees up as its last pending beat moves out
    assign drain_busy = pending && !(emit && (rest == '0));

    // pending ranks of the captured list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (snap_load)
            mask_reg <= snap_valid;
        else if (emit)
            mask_reg <= rest;
    end

    // captured list payload
    always_ff @(posedge clk)
    begin
        if (snap_load)
            list_reg <= snap_pt;
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_rank_reg <= tkps_pkg::RANK_W'(pick_idx);
            out_pt_reg   <= list_reg[pick_idx];
            out_last_reg <= (rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_pt_reg, out_rank_reg};

endmodule

@@ design/tkps_checker.sv @@
// port-level checks for the top-k height point selector, bound to the top level
module tkps_checker
#(
    parameter int NUM_CELLS = tkps_pkg::DEF_NUM_CELLS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [tkps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tlast
);

    logic                           in_run_reg;
    logic [tkps_pkg::RANK_W-1:0]    prev_rank_reg;
    logic                           out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    // track the rank of the previous beat within a report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg    <= 1'b0;
            prev_rank_reg <= '0;
        end
        else if (out_beat)
        begin
            in_run_reg    <= !m_axis_tlast;
            prev_rank_reg <= m_axis_tdata[tkps_pkg::RANK_W-1:0];
        end
    end

    // no report beat once reset has been seen
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("report beat shown during reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled report beat changed");

    // rank stays inside the cell array
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[tkps_pkg::RANK_W-1:0]) < NUM_CELLS))
        else $error("rank beyond the cell count");

    // ranks rise strictly within one report
    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && in_run_reg) |->
        (m_axis_tdata[tkps_pkg::RANK_W-1:0] > prev_rank_reg))
        else $error("report ranks out of order");

endmodule

bind top_k_height_point_select_top tkps_checker #(.NUM_CELLS(NUM_CELLS)) u_tkps_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
